>>> hw/rtl/mrbc_pkg.sv
// shared types and constants of the mrt bgp4mp record classifier
package mrbc_pkg;

    // width of the statistics counters; results carry the low 32 bits
    localparam int COUNT_WIDTH = 32;

    localparam int NUM_COUNTERS = 12;
    localparam logic [3:0] CNT_RECORDS  = 4'd10;
    localparam logic [3:0] CNT_MESSAGES = 4'd11;

    // mrt common header: 4 timestamp, 2 type, 2 subtype, 4 length
    localparam logic [3:0] HDR_LEN        = 4'd12;
    localparam logic [3:0] HDR_FIELDS_POS = 4'd4;

    // configuration register indexes
    localparam logic CFG_EXPECTED_TYPE = 1'b0;
    localparam logic CFG_WANTED_AFI    = 1'b1;

    // bgp4mp subtypes
    localparam logic [15:0] SUB_STATE_CHANGE     = 16'd0;
    localparam logic [15:0] SUB_MESSAGE          = 16'd1;
    localparam logic [15:0] SUB_MESSAGE_AS4      = 16'd4;
    localparam logic [15:0] SUB_STATE_CHANGE_AS4 = 16'd5;

    // bgp message typecodes
    localparam logic [7:0] BGP_OPEN         = 8'd1;
    localparam logic [7:0] BGP_UPDATE       = 8'd2;
    localparam logic [7:0] BGP_NOTIFICATION = 8'd3;
    localparam logic [7:0] BGP_KEEPALIVE    = 8'd4;

    // length limits
    localparam logic [31:0] MIN_RECORD_LEN  = 32'd12;
    localparam logic [31:0] MIN_AS4_MSG_LEN = 32'd39;
    localparam logic [31:0] MIN_UPDATE_LEN  = 32'd41;
    localparam logic [31:0] BGP_MSG_SKIP    = 32'd20;
    localparam logic [31:0] PAYLOAD_SKIP    = 32'd32;
    localparam logic [15:0] EOR_BGP_LEN     = 16'd23;

    typedef enum logic [3:0] {
        CLS_AFI_DISCARD  = 4'd0,
        CLS_AS2_DISCARD  = 4'd1,
        CLS_STATE_CHANGE = 4'd2,
        CLS_OPEN         = 4'd3,
        CLS_UPDATE       = 4'd4,
        CLS_WITHDRAW     = 4'd5,
        CLS_MIXED        = 4'd6,
        CLS_EOR          = 4'd7,
        CLS_NOTIFICATION = 4'd8,
        CLS_KEEPALIVE    = 4'd9,
        CLS_UNKNOWN_SUB  = 4'd10,
        CLS_BAD_TYPE     = 4'd11,
        CLS_BAD_TYPECODE = 4'd12,
        CLS_SHORT        = 4'd13
    } t_rec_class;

    typedef struct packed {
        logic [15:0] expected_type;
        logic [15:0] wanted_afi;
    } t_cfg;

    // record fields as they stand once the current byte is taken in
    typedef struct packed {
        logic        complete;
        logic        last;
        logic [15:0] rec_type;
        logic [15:0] subtype;
        logic [31:0] body_len;
        logic [31:0] start;
        logic [15:0] afi;
        logic [15:0] bgp_len;
        logic [7:0]  typecode;
        logic [15:0] wdr_len;
    } t_rec_view;

    typedef struct packed {
        t_rec_class  rec_class;
        logic [31:0] record_number;
        logic [31:0] class_count;
        logic [31:0] payload_offset;
        logic [31:0] payload_length;
        logic        keep_payload;
    } t_result;

endpackage

>>> hw/rtl/mrt_bgp4mp_record_classifier_top.sv
// top level of the mrt bgp4mp record classifier
//
// input stream: one byte of an mrt dump per request on s_axis; tdata holds
// the byte, tlast marks the final byte of the dump. each record's 12-byte
// header is parsed, bgp4mp records are sorted and as4 ipv4 messages
// classified from the afi, bgp length, typecode and withdrawn length bytes.
// output stream: one request on m_axis per finished or truncated record.
// result path: the record's last byte is loaded into the input register,
// then the result it gives is loaded into the result register.
// throughput: one byte per cycle unless a record end waits on the result
// register; every byte takes one combinational pass between the registers.
// stall: a byte that ends neither a record nor the dump moves on even while
// a result waits; only a byte that ends one waits for the result register
// to drain, and the input register then holds it while s_axis tready drops.
// config: i_cfg_we writes register i_cfg_index (0 expected record type, 1
// wanted address family); the user writes only while the stream is idle;
// the block does not enforce it. reset: clears counters, stream position
// and halt; registers return to type 16 and afi 1. after a bad type or bad
// typecode the block halts: bytes are still taken but dropped until reset.
module mrt_bgp4mp_record_classifier_top (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // byte stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // [7:0] data_byte
    input  logic         i_s_axis_tlast,   // end_of_file
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] record_number, [63:32] class_count,
    // [95:64] payload_offset, [127:96] payload_length
    output logic [127:0] o_m_axis_tdata,
    // [3:0] record_class, [4] keep_payload
    output logic [4:0]   o_m_axis_tuser,
    // configuration writes
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [15:0]  i_cfg_wdata
);
    import mrbc_pkg::*;

    // input register
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_last;

    // result register
    logic        r_out_valid;
    t_result     r_out;

    t_cfg        r_cfg;
    t_rec_view   w_view;
    t_result     w_result;
    logic        w_halted;
    logic        w_has_result;
    logic        w_out_free;
    logic        w_advance;
    logic        w_step;

    // a byte gives a result when it ends a record or the dump
    assign w_has_result = !w_halted && (w_view.complete || w_view.last);
    assign w_out_free   = !r_out_valid || i_m_axis_tready;
    assign w_advance    = r_in_valid && (!w_has_result || w_out_free);
    assign w_step       = w_advance && !w_halted;

    assign o_s_axis_tready = !r_in_valid || w_advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_axis_tready) begin
            r_in_byte <= i_s_axis_tdata;
            r_in_last <= i_s_axis_tlast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.expected_type <= 16'd16;
            r_cfg.wanted_afi    <= 16'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_EXPECTED_TYPE: r_cfg.expected_type <= i_cfg_wdata;
                CFG_WANTED_AFI:    r_cfg.wanted_afi    <= i_cfg_wdata;
                default:           ;
            endcase
        end
    end

    mrbc_parse u_parse (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (w_step),
        .i_byte  (r_in_byte),
        .i_last  (r_in_last),
        .o_view  (w_view)
    );

    mrbc_stats u_stats (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_view   (w_view),
        .i_cfg    (r_cfg),
        .o_result (w_result),
        .o_halted (w_halted)
    );

    // result register: loads on a record or dump end, clears when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_step && w_has_result) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step && w_has_result) begin
            r_out <= w_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {r_out.payload_length, r_out.payload_offset,
                              r_out.class_count, r_out.record_number};
    assign o_m_axis_tuser  = {r_out.keep_payload, r_out.rec_class};

    // halt stays until reset
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_halted |=> w_halted)
        else $error("halt flag cleared without reset");

    // the input side only stalls behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !o_s_axis_tready) |-> (r_out_valid && !i_m_axis_tready))
        else $error("input stalled while result register free");

    // a result is never loaded over one that is not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_step && w_has_result) |-> w_out_free)
        else $error("result register overwritten");

    // keep flag goes only with plain updates
    a_keep_update: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tuser[4]) |-> (r_out.rec_class == CLS_UPDATE))
        else $error("keep flag on a non-update record");

endmodule

>>> hw/rtl/mrbc_parse.sv
// byte-level parser: header and body position, field capture
module mrbc_parse (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  logic [7:0]         i_byte,
    input  logic               i_last,
    output mrbc_pkg::t_rec_view o_view
);
    import mrbc_pkg::*;

    // body offsets of the captured bytes
    localparam logic [31:0] OFS_AFI_HI  = 32'd10;
    localparam logic [31:0] OFS_AFI_LO  = 32'd11;
    localparam logic [31:0] OFS_BLEN_HI = 32'd36;
    localparam logic [31:0] OFS_BLEN_LO = 32'd37;
    localparam logic [31:0] OFS_TCODE   = 32'd38;
    localparam logic [31:0] OFS_WLEN_HI = 32'd39;
    localparam logic [31:0] OFS_WLEN_LO = 32'd40;

    logic [3:0]  r_hdr_cnt, n_hdr_cnt;
    logic [31:0] r_pos, n_pos;
    logic [31:0] r_body_cnt, n_body_cnt;
    logic [31:0] r_start;
    logic [63:0] r_hdr, n_hdr;
    logic [31:0] r_len, n_len;
    logic [15:0] r_afi, n_afi;
    logic [15:0] r_blen, n_blen;
    logic [7:0]  r_tcode, n_tcode;
    logic [15:0] r_wlen, n_wlen;

    logic        w_fresh;
    logic        w_complete;
    logic [31:0] w_start;
    logic [3:0]  w_hdr_inc;

    always_comb begin
        w_fresh    = (r_hdr_cnt == '0);
        w_start    = w_fresh ? r_pos : r_start;
        n_hdr      = w_fresh ? '0 : r_hdr;
        n_len      = w_fresh ? '0 : r_len;
        n_afi      = w_fresh ? '0 : r_afi;
        n_blen     = w_fresh ? '0 : r_blen;
        n_tcode    = w_fresh ? '0 : r_tcode;
        n_wlen     = w_fresh ? '0 : r_wlen;
        n_body_cnt = w_fresh ? '0 : r_body_cnt;
        w_hdr_inc  = r_hdr_cnt + 4'd1;
        w_complete = 1'b0;
        if (r_hdr_cnt < HDR_LEN) begin
            // timestamp bytes are skipped
            if (r_hdr_cnt >= HDR_FIELDS_POS) begin
                n_hdr = {n_hdr[55:0], i_byte};
            end
            if (w_hdr_inc == HDR_LEN) begin
                n_len      = n_hdr[31:0];
                w_complete = (n_hdr[31:0] == '0);
            end
        end else begin
            if (n_body_cnt == OFS_AFI_HI)  n_afi[15:8]  = i_byte;
            if (n_body_cnt == OFS_AFI_LO)  n_afi[7:0]   = i_byte;
            if (n_body_cnt == OFS_BLEN_HI) n_blen[15:8] = i_byte;
            if (n_body_cnt == OFS_BLEN_LO) n_blen[7:0]  = i_byte;
            if (n_body_cnt == OFS_TCODE)   n_tcode      = i_byte;
            if (n_body_cnt == OFS_WLEN_HI) n_wlen[15:8] = i_byte;
            if (n_body_cnt == OFS_WLEN_LO) n_wlen[7:0]  = i_byte;
            n_body_cnt = n_body_cnt + 32'd1;
            w_complete = (n_body_cnt == n_len);
        end
        // record end or end of dump restarts the header
        n_pos     = r_pos + 32'd1;
        n_hdr_cnt = (r_hdr_cnt < HDR_LEN) ? w_hdr_inc : r_hdr_cnt;
        if (w_complete || i_last) begin
            n_hdr_cnt = '0;
        end
        if (i_last) begin
            n_pos = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_cnt <= '0;
            r_pos     <= '0;
        end else if (i_step) begin
            r_hdr_cnt <= n_hdr_cnt;
            r_pos     <= n_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_body_cnt <= n_body_cnt;
            r_start    <= w_start;
            r_hdr      <= n_hdr;
            r_len      <= n_len;
            r_afi      <= n_afi;
            r_blen     <= n_blen;
            r_tcode    <= n_tcode;
            r_wlen     <= n_wlen;
        end
    end

    always_comb begin
        o_view.complete = w_complete;
        o_view.last     = i_last;
        o_view.rec_type = n_hdr[63:48];
        o_view.subtype  = n_hdr[47:32];
        o_view.body_len = n_len;
        o_view.start    = w_start;
        o_view.afi      = n_afi;
        o_view.bgp_len  = n_blen;
        o_view.typecode = n_tcode;
        o_view.wdr_len  = n_wlen;
    end

endmodule

>>> hw/rtl/mrbc_stats.sv
// record classification, statistics counters and halt flag
module mrbc_stats (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_step,
    input  mrbc_pkg::t_rec_view i_view,
    input  mrbc_pkg::t_cfg      i_cfg,
    output mrbc_pkg::t_result   o_result,
    output logic                o_halted
);
    import mrbc_pkg::*;

    typedef enum logic [1:0] {
        SEL_ZERO = 2'b00,
        SEL_REC  = 2'b01,
        SEL_CLS  = 2'b10
    } t_cnt_sel;

    logic [COUNT_WIDTH-1:0] r_cnt [NUM_COUNTERS];
    logic                   r_halted;

    t_rec_class             w_cls;
    t_cnt_sel               w_sel;
    logic                   w_normal;
    logic                   w_inc_rec;
    logic                   w_inc_msg;
    logic                   w_halt;
    logic [3:0]             w_cls_idx;
    logic [COUNT_WIDTH-1:0] w_rec_new;
    logic [COUNT_WIDTH-1:0] w_cls_new;
    logic [COUNT_WIDTH-1:0] w_count;
    logic                   w_short_msg;
    logic [16:0]            w_wdr_eor;

    always_comb begin
        w_cls       = CLS_SHORT;
        w_sel       = SEL_ZERO;
        w_normal    = 1'b0;
        w_inc_rec   = 1'b0;
        w_inc_msg   = 1'b0;
        w_halt      = 1'b0;
        w_wdr_eor   = 17'(i_view.wdr_len) + 17'(EOR_BGP_LEN);
        w_short_msg = (i_view.body_len < MIN_AS4_MSG_LEN)
                   || ((i_view.typecode == BGP_UPDATE)
                       && (i_view.bgp_len != EOR_BGP_LEN)
                       && (i_view.body_len < MIN_UPDATE_LEN));
        if (!i_view.complete) begin
            // truncated by end of dump: no counter moves
            w_cls = CLS_SHORT;
        end else if (i_view.rec_type != i_cfg.expected_type) begin
            w_cls  = CLS_BAD_TYPE;
            w_halt = 1'b1;
        end else if (i_view.body_len < MIN_RECORD_LEN) begin
            w_cls     = CLS_SHORT;
            w_inc_rec = 1'b1;
        end else if (i_view.afi != i_cfg.wanted_afi) begin
            w_cls    = CLS_AFI_DISCARD;
            w_normal = 1'b1;
        end else if (i_view.subtype == SUB_MESSAGE_AS4) begin
            if (w_short_msg) begin
                w_cls     = CLS_SHORT;
                w_inc_rec = 1'b1;
            end else begin
                w_inc_msg = 1'b1;
                w_normal  = 1'b1;
                unique case (i_view.typecode)
                    BGP_OPEN:         w_cls = CLS_OPEN;
                    BGP_UPDATE: begin
                        if (i_view.bgp_len == EOR_BGP_LEN) begin
                            w_cls = CLS_EOR;
                        end else if (i_view.wdr_len == '0) begin
                            w_cls = CLS_UPDATE;
                        end else if (17'(i_view.bgp_len) != w_wdr_eor) begin
                            w_cls = CLS_MIXED;
                        end else begin
                            w_cls = CLS_WITHDRAW;
                        end
                    end
                    BGP_NOTIFICATION: w_cls = CLS_NOTIFICATION;
                    BGP_KEEPALIVE:    w_cls = CLS_KEEPALIVE;
                    default: begin
                        w_cls     = CLS_BAD_TYPECODE;
                        w_normal  = 1'b0;
                        w_inc_rec = 1'b1;
                        w_halt    = 1'b1;
                    end
                endcase
            end
        end else if (i_view.subtype == SUB_STATE_CHANGE_AS4) begin
            w_cls    = CLS_STATE_CHANGE;
            w_normal = 1'b1;
        end else if (i_view.subtype == SUB_STATE_CHANGE
                  || i_view.subtype == SUB_MESSAGE) begin
            w_cls    = CLS_AS2_DISCARD;
            w_normal = 1'b1;
        end else begin
            w_cls     = CLS_UNKNOWN_SUB;
            w_inc_rec = 1'b1;
            w_sel     = SEL_REC;
        end
        if (w_normal) begin
            w_inc_rec = 1'b1;
            w_sel     = SEL_CLS;
        end
    end

    always_comb begin
        w_cls_idx = w_normal ? w_cls : '0;
        w_rec_new = r_cnt[CNT_RECORDS] + COUNT_WIDTH'(1);
        w_cls_new = r_cnt[w_cls_idx] + COUNT_WIDTH'(1);
        unique case (w_sel)
            SEL_REC: w_count = w_rec_new;
            SEL_CLS: w_count = w_cls_new;
            default: w_count = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_cnt[i] <= '0;
            end
            r_halted <= 1'b0;
        end else if (i_step) begin
            if (w_inc_rec) begin
                r_cnt[CNT_RECORDS] <= w_rec_new;
            end
            if (w_inc_msg) begin
                r_cnt[CNT_MESSAGES] <= r_cnt[CNT_MESSAGES] + COUNT_WIDTH'(1);
            end
            if (w_normal) begin
                r_cnt[w_cls_idx] <= w_cls_new;
            end
            if (w_halt) begin
                r_halted <= 1'b1;
            end
        end
    end

    always_comb begin
        o_result.rec_class      = w_cls;
        o_result.record_number  = 32'(r_cnt[CNT_RECORDS]);
        o_result.class_count    = 32'(w_count);
        o_result.payload_offset = i_view.start + PAYLOAD_SKIP;
        o_result.payload_length = (i_view.body_len >= BGP_MSG_SKIP)
                                ? (i_view.body_len - BGP_MSG_SKIP) : '0;
        o_result.keep_payload   = (w_cls == CLS_UPDATE);
    end

    assign o_halted = r_halted;

endmodule
